### src/scpb_pkg.sv
// ----------------------------------------------------------------------------
// scpb_pkg
// Types and constants shared by the swap command packet builder.
// ----------------------------------------------------------------------------
package scpb_pkg;

  localparam int CommandLengthDefault = 64;
  localparam int QueueDepth           = 2;
  localparam int FetchWords           = 6;

  localparam logic [31:0] HdrType0Fetch = 32'h0005_4800;
  localparam logic [31:0] HdrType3Swap  = 32'hC003_6400;
  localparam logic [31:0] SwapSignature = 32'h5041_5753;
  localparam logic [31:0] PadWord       = 32'h8000_0000;
  localparam logic [31:0] AddrLimit     = 32'hFFFF_FFFC;
  localparam logic [31:0] FrontMask     = 32'hFFFF_F000;
  localparam logic [1:0]  FetchType2D   = 2'd2;

  // Fixed word positions in the command buffer
  localparam logic [5:0] PosHdr0   = 6'd0;
  localparam logic [5:0] PosFetch0 = 6'd1;
  localparam logic [5:0] PosFetch5 = 6'd6;
  localparam logic [5:0] PosHdr3   = 6'd7;
  localparam logic [5:0] PosSig    = 6'd8;
  localparam logic [5:0] PosFront  = 6'd9;
  localparam logic [5:0] PosWidth  = 6'd10;
  localparam logic [5:0] PosHeight = 6'd11;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // One classified request waiting for the emitter
  typedef struct packed {
    logic                          reject;
    logic [31:0]                   buffer_address;
    logic [FetchWords-1:0][31:0]   fetch_word;
  } scpb_entry_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic ready;
  } scpb_flow_t;

endpackage

### src/scpb_req_if.sv
// ----------------------------------------------------------------------------
// scpb_req_if
// Request channel: one swap request per word.
// ----------------------------------------------------------------------------
interface scpb_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] buffer_address;
  logic [31:0] fetch_word_0;
  logic [31:0] fetch_word_1;
  logic [31:0] fetch_word_2;
  logic [31:0] fetch_word_3;
  logic [31:0] fetch_word_4;
  logic [31:0] fetch_word_5;
  logic [31:0] claimed_frontbuffer;
  logic [31:0] claimed_format;
  logic [31:0] colorspace;
  logic        sources_ok;

  modport source (
    output valid, buffer_address, fetch_word_0, fetch_word_1, fetch_word_2,
           fetch_word_3, fetch_word_4, fetch_word_5, claimed_frontbuffer,
           claimed_format, colorspace, sources_ok,
    input  ready
  );
  modport sink (
    input  valid, buffer_address, fetch_word_0, fetch_word_1, fetch_word_2,
           fetch_word_3, fetch_word_4, fetch_word_5, claimed_frontbuffer,
           claimed_format, colorspace, sources_ok,
    output ready
  );
endinterface

### src/scpb_word_if.sv
// ----------------------------------------------------------------------------
// scpb_word_if
// Result channel: one command word or one reject result per word.
// ----------------------------------------------------------------------------
interface scpb_word_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [5:0]  word_index;
  logic [31:0] word_address;
  logic [31:0] word_value;
  logic        last;

  modport source (
    output valid, status, word_index, word_address, word_value, last,
    input  ready
  );
  modport sink (
    input  valid, status, word_index, word_address, word_value, last,
    output ready
  );
endinterface

### src/scpb_front.sv
// ----------------------------------------------------------------------------
// scpb_front
// Accepts swap requests, runs the validity checks and packs a queue entry.
// ----------------------------------------------------------------------------
module scpb_front
  import scpb_pkg::*;
#(
  parameter int COMMAND_LENGTH = CommandLengthDefault
) (
  scpb_req_if.sink          req,
  output scpb_flow_t        push,
  input  logic              queue_ready,
  output scpb_entry_t       entry
);

  // Highest start address that keeps the last word at or below the limit
  localparam logic [31:0] AddrMax = AddrLimit - 32'((COMMAND_LENGTH - 1) * 4);

  logic [31:0] frontbuffer;
  logic [31:0] tex_format;
  logic        bad;

  // Classify the request
  always_comb begin
    frontbuffer = req.fetch_word_1 & FrontMask;
    tex_format  = {26'd0, req.fetch_word_1[5:0]};
    bad = !req.sources_ok
       || (req.buffer_address == 32'd0)
       || (req.buffer_address > AddrMax)
       || (req.fetch_word_0[1:0] != FetchType2D)
       || (frontbuffer == 32'd0)
       || (req.claimed_frontbuffer != frontbuffer)
       || (req.claimed_format != tex_format)
       || (req.colorspace != 32'd0);
  end

  // Pack the entry
  always_comb begin
    entry.reject         = bad;
    entry.buffer_address = req.buffer_address;
    entry.fetch_word[0]  = req.fetch_word_0;
    entry.fetch_word[1]  = req.fetch_word_1;
    entry.fetch_word[2]  = req.fetch_word_2;
    entry.fetch_word[3]  = req.fetch_word_3;
    entry.fetch_word[4]  = req.fetch_word_4;
    entry.fetch_word[5]  = req.fetch_word_5;
  end

  assign push      = '{valid: req.valid, ready: queue_ready};
  assign req.ready = queue_ready;

endmodule

### src/scpb_queue.sv
// ----------------------------------------------------------------------------
// scpb_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module scpb_queue
  import scpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  scpb_flow_t  push,
  input  scpb_entry_t push_entry,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output scpb_entry_t head
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  scpb_entry_t           mem [QueueDepth];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == CntW'(QueueDepth));
  assign empty   = (count == '0);
  assign do_push = push.valid && push.ready;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !do_push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty && !do_push |=> empty)
    else $error("queue count moved without a write");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

endmodule

### src/scpb_back.sv
// ----------------------------------------------------------------------------
// scpb_back
// Walks the head entry and emits its command words, or one reject result.
// ----------------------------------------------------------------------------
module scpb_back
  import scpb_pkg::*;
#(
  parameter int COMMAND_LENGTH = CommandLengthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  scpb_entry_t   head,
  output logic          pop,
  scpb_word_if.source   word
);

  localparam logic [5:0] IdxLast = 6'(COMMAND_LENGTH - 1);

  logic [5:0]  idx;
  logic        advance;
  logic        head_done;
  logic [31:0] cur_value;
  logic [13:0] width_val;
  logic [13:0] height_val;

  // Status kept across requests
  logic [31:0] success_count;
  logic [31:0] failure_count;
  logic [31:0] last_buffer;
  logic [31:0] last_frontbuffer;
  logic [13:0] last_width;
  logic [13:0] last_height;

  assign advance    = !word.valid || word.ready;
  assign head_done  = head.reject || (idx == IdxLast);
  assign pop        = advance && !empty && head_done;
  assign width_val  = {1'b0, head.fetch_word[2][12:0]} + 14'd1;
  assign height_val = {1'b0, head.fetch_word[2][25:13]} + 14'd1;

  // Select the word at the current position
  always_comb begin
    if (idx == PosHdr0) begin
      cur_value = HdrType0Fetch;
    end else if (idx >= PosFetch0 && idx <= PosFetch5) begin
      cur_value = head.fetch_word[3'(idx - PosFetch0)];
    end else if (idx == PosHdr3) begin
      cur_value = HdrType3Swap;
    end else if (idx == PosSig) begin
      cur_value = SwapSignature;
    end else if (idx == PosFront) begin
      cur_value = head.fetch_word[1] & FrontMask;
    end else if (idx == PosWidth) begin
      cur_value = {18'd0, width_val};
    end else if (idx == PosHeight) begin
      cur_value = {18'd0, height_val};
    end else begin
      cur_value = PadWord;
    end
  end

  // Output register and word position
  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
      idx        <= '0;
    end else if (advance) begin
      word.valid <= !empty;
      if (!empty) begin
        idx <= head_done ? '0 : idx + 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      if (head.reject) begin
        word.status       <= STATUS_REJECT;
        word.word_index   <= '0;
        word.word_address <= '0;
        word.word_value   <= '0;
        word.last         <= 1'b1;
      end else begin
        word.status       <= STATUS_OK;
        word.word_index   <= idx;
        word.word_address <= head.buffer_address + {24'd0, idx, 2'b00};
        word.word_value   <= cur_value;
        word.last         <= (idx == IdxLast);
      end
    end
  end

  // Update counters on completion, and the last request only on success
  always_ff @(posedge clk) begin
    if (rst) begin
      success_count    <= '0;
      failure_count    <= '0;
      last_buffer      <= '0;
      last_frontbuffer <= '0;
      last_width       <= '0;
      last_height      <= '0;
    end else if (pop) begin
      if (head.reject) begin
        failure_count <= failure_count + 32'd1;
      end else begin
        success_count    <= success_count + 32'd1;
        last_buffer      <= head.buffer_address;
        last_frontbuffer <= head.fetch_word[1] & FrontMask;
        last_width       <= width_val;
        last_height      <= height_val;
      end
    end
  end

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    word.valid && word.ready && !word.last |=>
      word.valid && (word.word_index == $past(word.word_index) + 6'd1))
    else $error("command word index did not advance by one");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    word.valid && (word.status == STATUS_REJECT) |->
      word.last && (word.word_value == 32'd0) && (word.word_address == 32'd0))
    else $error("malformed reject result");

  a_fail_count: assert property (@(posedge clk) disable iff (rst)
    pop && head.reject |=> failure_count == $past(failure_count) + 32'd1)
    else $error("failure count not advanced");

  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    pop && !head.reject |=>
      (success_count == $past(success_count) + 32'd1)
      && (last_buffer == $past(head.buffer_address))
      && (last_frontbuffer[11:0] == 12'd0) && (last_width != 14'd0)
      && (last_height != 14'd0))
    else $error("success status not updated");

endmodule

### src/swap_command_packet_builder.sv
// ----------------------------------------------------------------------------
// swap_command_packet_builder
// Checks a display swap request and emits its command buffer word by word.
// ----------------------------------------------------------------------------
// A request is accepted on its handshake and classified at once; a two-entry queue
// lets the next request come in while the emitter is busy. A valid request
// produces COMMAND_LENGTH command words, one per cycle while the receiver takes
// them, with index, byte address and value; a rejected request produces a single
// result with status set. The emitter puts out one word a cycle through its output
// register unless the receiver stalls it.
module swap_command_packet_builder
  import scpb_pkg::*;
#(
  parameter int COMMAND_LENGTH = CommandLengthDefault
) (
  input  logic        clk,
  input  logic        rst,
  scpb_req_if.sink    req,
  scpb_word_if.source cmd
);

  scpb_flow_t  push;
  scpb_entry_t push_entry;
  scpb_entry_t head;
  logic        full;
  logic        empty;
  logic        pop;

  scpb_front #(
    .COMMAND_LENGTH (COMMAND_LENGTH)
  ) u_front (
    .req         (req),
    .push        (push),
    .queue_ready (!full),
    .entry       (push_entry)
  );

  scpb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .head       (head)
  );

  scpb_back #(
    .COMMAND_LENGTH (COMMAND_LENGTH)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .word  (cmd)
  );

endmodule

### bench/tb_swap_command_packet_builder.sv
// ----------------------------------------------------------------------------
// tb_swap_command_packet_builder
// Self-checking bench for the swap command packet builder. Swap requests are
// offered from a queue with random gaps, and the command words are taken with
// random stalls, including two long hold-offs. Every word is compared field by
// field with the command buffer that the bench builds on its own.
// ----------------------------------------------------------------------------
module tb_swap_command_packet_builder;
  import scpb_pkg::*;

  localparam int          CmdLength   = CommandLengthDefault;
  localparam int          RandomItems = 410;
  localparam int          WatchLimit  = 4000;
  localparam int          LongHold    = 700;
  localparam int          TailCycles  = 200;
  localparam int          PrintLimit  = 30;

  // Ways a request is spoiled so that the block must reject it
  typedef enum int {
    FLAW_NONE,
    FLAW_SOURCES,
    FLAW_NULL_BUFFER,
    FLAW_OVERFLOW,
    FLAW_FETCH_TYPE,
    FLAW_NULL_FRONT,
    FLAW_FRONT_MISMATCH,
    FLAW_FORMAT_MISMATCH,
    FLAW_COLOR_SPACE,
    FLAW_NOISE
  } flaw_e;

  typedef struct {
    logic [31:0] buffer_address;
    logic [31:0] fetch_word [FetchWords];
    logic [31:0] claimed_frontbuffer;
    logic [31:0] claimed_format;
    logic [31:0] colorspace;
    logic        sources_ok;
  } swap_request_t;

  typedef struct {
    logic        status;
    logic [5:0]  index;
    logic [31:0] address;
    logic [31:0] value;
    logic        last;
  } command_word_t;

  logic clk;
  logic rst;

  scpb_req_if  req_bus ();
  scpb_word_if word_bus ();

  swap_command_packet_builder dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .cmd (word_bus)
  );

  swap_request_t pending_requests [$];
  swap_request_t offered;
  command_word_t expected_words [$];

  // Bench copy of the block state
  logic [31:0] success_total;
  logic [31:0] failure_total;
  logic [31:0] last_buffer_seen;
  logic [31:0] last_front_seen;
  logic [13:0] last_width_seen;
  logic [13:0] last_height_seen;

  int unsigned mismatch_count = 0;
  int unsigned words_taken    = 0;
  int unsigned idle_cycles    = 0;
  int unsigned req_gap        = 0;
  int unsigned word_stall     = 0;
  int unsigned hold_left      = 0;
  bit          req_fired      = 1'b0;
  bit          word_fired     = 1'b0;
  bit          req_calm       = 1'b0;
  bit          word_calm      = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PrintLimit) begin
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Draw the wait before the next word; flip between calm and busy stretches
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 24) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Make the declared frontbuffer and format agree with fetch word 1
  function automatic void align_declared(inout swap_request_t r);
    r.claimed_frontbuffer = r.fetch_word[1] & FrontMask;
    r.claimed_format      = {26'd0, r.fetch_word[1][5:0]};
  endfunction

  function automatic swap_request_t build_request(flaw_e flaw);
    swap_request_t r;
    logic [1:0]    kind;
    r.buffer_address = $urandom_range(32'hFFFF_FF00, 32'd1);
    if ($urandom_range(0, 15) == 0) begin
      r.buffer_address = 32'hFFFF_FF00 - $urandom_range(0, 64);
    end
    for (int i = 0; i < FetchWords; i++) begin
      r.fetch_word[i] = $urandom();
    end
    r.fetch_word[0][1:0] = FetchType2D;
    if (r.fetch_word[1][31:12] == 20'd0) begin
      r.fetch_word[1][12] = 1'b1;
    end
    // keep some sizes small
    if ($urandom_range(0, 3) == 0) begin
      r.fetch_word[2][25:0] = {7'd0, 6'($urandom_range(0, 63)),
                               7'd0, 6'($urandom_range(0, 63))};
    end
    align_declared(r);
    r.colorspace = 32'd0;
    r.sources_ok = 1'b1;
    case (flaw)
      FLAW_SOURCES: begin
        r.sources_ok = 1'b0;
      end
      FLAW_NULL_BUFFER: begin
        r.buffer_address = 32'd0;
      end
      FLAW_OVERFLOW: begin
        r.buffer_address = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF01);
      end
      FLAW_FETCH_TYPE: begin
        kind = 2'($urandom_range(0, 2));
        r.fetch_word[0][1:0] = (kind == FetchType2D) ? 2'd3 : kind;
      end
      FLAW_NULL_FRONT: begin
        r.fetch_word[1][31:12] = 20'd0;
        align_declared(r);
      end
      FLAW_FRONT_MISMATCH: begin
        r.claimed_frontbuffer ^= ($urandom() | (32'd1 << $urandom_range(0, 31)));
      end
      FLAW_FORMAT_MISMATCH: begin
        r.claimed_format ^= ($urandom() | (32'd1 << $urandom_range(0, 31)));
      end
      FLAW_COLOR_SPACE: begin
        r.colorspace = $urandom() | (32'd1 << $urandom_range(0, 31));
      end
      FLAW_NOISE: begin
        r.buffer_address      = $urandom();
        r.claimed_frontbuffer = $urandom();
        r.claimed_format      = $urandom();
        r.colorspace          = $urandom();
        r.sources_ok          = 1'($urandom_range(0, 1));
        for (int i = 0; i < FetchWords; i++) begin
          r.fetch_word[i] = $urandom();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Build the command buffer for one accepted request, or its reject result
  function automatic void predict_command_words(swap_request_t r);
    command_word_t w;
    logic [31:0]   front;
    logic [5:0]    format;
    logic [13:0]   width;
    logic [13:0]   height;
    logic [32:0]   tail;
    logic [5:0]    pos;
    front  = r.fetch_word[1] & FrontMask;
    format = r.fetch_word[1][5:0];
    width  = {1'b0, r.fetch_word[2][12:0]} + 14'd1;
    height = {1'b0, r.fetch_word[2][25:13]} + 14'd1;
    tail   = {1'b0, r.buffer_address} + 33'(4 * (CmdLength - 1));
    if (!r.sources_ok || r.buffer_address == 32'd0 || tail > {1'b0, AddrLimit} ||
        r.fetch_word[0][1:0] != FetchType2D || front == 32'd0 ||
        r.claimed_frontbuffer != front || r.claimed_format != {26'd0, format} ||
        r.colorspace != 32'd0) begin
      w.status  = STATUS_REJECT;
      w.index   = 6'd0;
      w.address = 32'd0;
      w.value   = 32'd0;
      w.last    = 1'b1;
      expected_words.push_back(w);
      failure_total++;
      return;
    end
    for (int i = 0; i < CmdLength; i++) begin
      pos = 6'(i);
      if (pos >= PosFetch0 && pos <= PosFetch5) begin
        w.value = r.fetch_word[pos - PosFetch0];
      end else begin
        case (pos)
          PosHdr0:   w.value = HdrType0Fetch;
          PosHdr3:   w.value = HdrType3Swap;
          PosSig:    w.value = SwapSignature;
          PosFront:  w.value = front;
          PosWidth:  w.value = {18'd0, width};
          PosHeight: w.value = {18'd0, height};
          default:   w.value = PadWord;
        endcase
      end
      w.status  = STATUS_OK;
      w.index   = pos;
      w.address = r.buffer_address + 32'(4 * i);
      w.last    = (i == CmdLength - 1);
      expected_words.push_back(w);
    end
    success_total++;
    last_buffer_seen = r.buffer_address;
    last_front_seen  = front;
    last_width_seen  = width;
    last_height_seen = height;
  endfunction

  // Offer requests: hold a word until taken, then wait the drawn gap
  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_fired) begin
      if (req_fired) begin
        req_fired = 1'b0;
        req_gap   = draw_wait(req_calm);
      end
      if (req_gap == 0 && pending_requests.size() > 0) begin
        offered = pending_requests.pop_front();
        req_bus.buffer_address      <= offered.buffer_address;
        req_bus.fetch_word_0        <= offered.fetch_word[0];
        req_bus.fetch_word_1        <= offered.fetch_word[1];
        req_bus.fetch_word_2        <= offered.fetch_word[2];
        req_bus.fetch_word_3        <= offered.fetch_word[3];
        req_bus.fetch_word_4        <= offered.fetch_word[4];
        req_bus.fetch_word_5        <= offered.fetch_word[5];
        req_bus.claimed_frontbuffer <= offered.claimed_frontbuffer;
        req_bus.claimed_format      <= offered.claimed_format;
        req_bus.colorspace          <= offered.colorspace;
        req_bus.sources_ok          <= offered.sources_ok;
        req_bus.valid               <= 1'b1;
      end else begin
        if (req_gap > 0) begin
          req_gap--;
        end
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Take command words: random stalls, plus a long hold-off twice in the run
  always @(negedge clk) begin
    if (rst) begin
      word_bus.ready <= 1'b0;
    end else begin
      if (word_fired) begin
        word_fired = 1'b0;
        if (words_taken == 40 || words_taken == 9000) begin
          hold_left = LongHold;
        end else begin
          word_stall = draw_wait(word_calm);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        word_bus.ready <= 1'b0;
      end else if (word_stall > 0) begin
        word_stall--;
        word_bus.ready <= 1'b0;
      end else begin
        word_bus.ready <= 1'b1;
      end
    end
  end

  // Predict on each accepted request, check each accepted word, watch for hangs
  always @(posedge clk) begin
    command_word_t want;
    if (!rst && req_bus.valid && req_bus.ready) begin
      predict_command_words(offered);
      req_fired = 1'b1;
    end
    if (!rst && word_bus.valid && word_bus.ready) begin
      words_taken++;
      word_fired = 1'b1;
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", word_bus.word_value, 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (word_bus.status !== want.status) begin
          report_mismatch("status", 32'(word_bus.status), 32'(want.status));
        end
        if (word_bus.word_index !== want.index) begin
          report_mismatch("word_index", 32'(word_bus.word_index), 32'(want.index));
        end
        if (word_bus.word_address !== want.address) begin
          report_mismatch("word_address", word_bus.word_address, want.address);
        end
        if (word_bus.word_value !== want.value) begin
          report_mismatch("word_value", word_bus.word_value, want.value);
        end
        if (word_bus.last !== want.last) begin
          report_mismatch("last", 32'(word_bus.last), 32'(want.last));
        end
      end
    end
    if (rst || (req_bus.valid && req_bus.ready) || (word_bus.valid && word_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("tb_swap_command_packet_builder NOT OK");
      $finish;
    end
  end

  initial begin
    swap_request_t r;
    int unsigned   pick;
    rst                         = 1'b1;
    req_bus.valid               = 1'b0;
    req_bus.buffer_address      = 32'd0;
    req_bus.fetch_word_0        = 32'd0;
    req_bus.fetch_word_1        = 32'd0;
    req_bus.fetch_word_2        = 32'd0;
    req_bus.fetch_word_3        = 32'd0;
    req_bus.fetch_word_4        = 32'd0;
    req_bus.fetch_word_5        = 32'd0;
    req_bus.claimed_frontbuffer = 32'd0;
    req_bus.claimed_format      = 32'd0;
    req_bus.colorspace          = 32'd0;
    req_bus.sources_ok          = 1'b0;
    word_bus.ready              = 1'b0;
    success_total    = 32'd0;
    failure_total    = 32'd0;
    last_buffer_seen = 32'd0;
    last_front_seen  = 32'd0;
    last_width_seen  = 14'd0;
    last_height_seen = 14'd0;

    // Smallest good request: 1x1, zero format, lowest frontbuffer
    r = build_request(FLAW_NONE);
    r.buffer_address = 32'h1000_0000;
    r.fetch_word[0]  = 32'h0000_0002;
    r.fetch_word[1]  = 32'h0000_1000;
    for (int i = 2; i < FetchWords; i++) begin
      r.fetch_word[i] = 32'd0;
    end
    align_declared(r);
    pending_requests.push_back(r);
    // Largest good request: last word lands exactly on the address limit
    r.buffer_address = 32'hFFFF_FF00;
    r.fetch_word[0]  = 32'hFFFF_FFFE;
    r.fetch_word[1]  = 32'hFFFF_F03F;
    for (int i = 2; i < FetchWords; i++) begin
      r.fetch_word[i] = 32'hFFFF_FFFF;
    end
    align_declared(r);
    pending_requests.push_back(r);
    // Unaligned buffer; bits between format and frontbuffer are ignored
    r.buffer_address = 32'd1;
    r.fetch_word[1]  = 32'h0000_1FC0;
    align_declared(r);
    pending_requests.push_back(r);
    // Width only at max, then height only at max
    r = build_request(FLAW_NONE);
    r.fetch_word[2] = 32'h0000_1FFF;
    pending_requests.push_back(r);
    r.fetch_word[2] = 32'hFC00_0000 | (32'h1FFF << 13);
    pending_requests.push_back(r);
    // Buffer running one byte and more past the limit
    r = build_request(FLAW_NONE);
    r.buffer_address = 32'hFFFF_FF01;
    pending_requests.push_back(r);
    r.buffer_address = 32'hFFFF_FF04;
    pending_requests.push_back(r);
    r.buffer_address = 32'hFFFF_FFFF;
    pending_requests.push_back(r);
    pending_requests.push_back(build_request(FLAW_NULL_BUFFER));
    pending_requests.push_back(build_request(FLAW_SOURCES));
    // Every fetch type other than 2D
    for (int t = 0; t < 4; t++) begin
      if (t != FetchType2D) begin
        r = build_request(FLAW_NONE);
        r.fetch_word[0][1:0] = 2'(t);
        pending_requests.push_back(r);
      end
    end
    pending_requests.push_back(build_request(FLAW_NULL_FRONT));
    // Declared frontbuffer carrying low bits the fetch masks off
    r = build_request(FLAW_NONE);
    r.claimed_frontbuffer = r.claimed_frontbuffer | 32'h0000_0001;
    pending_requests.push_back(r);
    pending_requests.push_back(build_request(FLAW_FRONT_MISMATCH));
    // Declared format differing only above the six format bits
    r = build_request(FLAW_NONE);
    r.claimed_format = r.claimed_format | 32'h8000_0000;
    pending_requests.push_back(r);
    pending_requests.push_back(build_request(FLAW_FORMAT_MISMATCH));
    r = build_request(FLAW_NONE);
    r.colorspace = 32'd1;
    pending_requests.push_back(r);
    r.colorspace = 32'h8000_0000;
    pending_requests.push_back(r);
    pending_requests.push_back(build_request(FLAW_NOISE));

    // Mostly good requests with random content, mixed with spoiled ones and noise
    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pending_requests.push_back(build_request(FLAW_NONE));
      end else if (pick < 90) begin
        pending_requests.push_back(build_request(flaw_e'($urandom_range(FLAW_SOURCES,
                                                                        FLAW_COLOR_SPACE))));
      end else begin
        pending_requests.push_back(build_request(FLAW_NOISE));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (pending_requests.size() == 0 && !req_bus.valid && expected_words.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("words never seen", 32'(expected_words.size()), 32'd0);
    end
    if (mismatch_count == 0) begin
      $display("tb_swap_command_packet_builder OK");
    end else begin
      $display("tb_swap_command_packet_builder NOT OK");
    end
    $finish;
  end

endmodule
